// File: rtl/core/sgpg_pkg.sv
package sgpg_pkg;

    localparam int PHASE_W     = 32;
    localparam int COS_ENTRIES = 1024;
    localparam int COS_IDX_W   = $clog2(COS_ENTRIES);
    localparam int QTR_W       = COS_IDX_W - 2;
    localparam int QTR_ENTRIES = COS_ENTRIES / 4;
    localparam int COS_W       = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_OFFSET = 3'd7;

    localparam logic [1:0] MODE_DRIFT  = 2'd0;
    localparam logic [1:0] MODE_OSC    = 2'd1;
    localparam logic [1:0] MODE_STATIC = 2'd2;

    localparam logic [1:0] SEG_BLANK    = 2'd0;
    localparam logic [1:0] SEG_GRATING  = 2'd1;
    localparam logic [1:0] SEG_REVERSED = 2'd2;

    typedef logic [COS_IDX_W-1:0] cos_idx_t;
    typedef logic [QTR_W-1:0] qtr_idx_t;
    typedef logic [QTR_ENTRIES-1:0][COS_W-2:0] qtr_rom_t;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [15:0] frame_index;
        logic [1:0]  segment;
    } pix_beat_t;

    typedef struct packed {
        logic [15:0] luminance;
        logic        clipped;
    } lum_beat_t;

    // Q30 Taylor series, rounded to Q15 magnitude
    function automatic logic [COS_W-2:0] series_q15(input logic [63:0] a, input logic is_sin);
        logic [63:0]        a2;
        logic [63:0]        term;
        logic [63:0]        p;
        logic [63:0]        rnd;
        logic signed [63:0] sum;
        int                 k;
        a2   = (a * a) >> 30;
        term = is_sin ? a : ONE_Q30;
        sum  = $signed(term);
        for (k = 1; k < 10; k++)
        begin
            p = (term * a2) >> 30;
            case (k)
                1:       term = is_sin ? p / 64'd6   : p / 64'd2;
                2:       term = is_sin ? p / 64'd20  : p / 64'd12;
                3:       term = is_sin ? p / 64'd42  : p / 64'd30;
                4:       term = is_sin ? p / 64'd72  : p / 64'd56;
                5:       term = is_sin ? p / 64'd110 : p / 64'd90;
                6:       term = is_sin ? p / 64'd156 : p / 64'd132;
                7:       term = is_sin ? p / 64'd210 : p / 64'd182;
                8:       term = is_sin ? p / 64'd272 : p / 64'd240;
                9:       term = is_sin ? p / 64'd342 : p / 64'd306;
                default: term = p;
            endcase
            if (k[0])
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        if (sum > $signed(ONE_Q30))
            sum = $signed(ONE_Q30);
        rnd = ($unsigned(sum) + 64'd16384) >> 15;
        if (rnd > 64'd32767)
            rnd = 64'd32767;
        return rnd[COS_W-2:0];
    endfunction

    function automatic qtr_rom_t gen_qtr(input logic is_sin);
        qtr_rom_t    rom;
        logic [63:0] r;
        logic [63:0] a;
        int          i;
        for (i = 0; i < QTR_ENTRIES; i++)
        begin
            r = 64'(i) << (PHASE_W - COS_IDX_W);
            a = (r * HALF_PI_Q30) >> 30;
            rom[i[QTR_W-1:0]] = series_q15(a, is_sin);
        end
        return rom;
    endfunction

    localparam qtr_rom_t COS_QTR = gen_qtr(1'b0);
    localparam qtr_rom_t SIN_QTR = gen_qtr(1'b1);

endpackage

// File: rtl/core/sgpg_cos_rom.sv
module sgpg_cos_rom (
    input  logic                                clk,
    input  logic                                load,
    input  sgpg_pkg::cos_idx_t                  idx,
    output logic signed [sgpg_pkg::COS_W-1:0]   value
);
    import sgpg_pkg::*;

    logic [1:0]               quad;
    qtr_idx_t                 qidx;
    logic [COS_W-2:0]         mag;
    logic signed [COS_W-1:0]  value_next;
    logic signed [COS_W-1:0]  value_reg;

    assign quad = idx[COS_IDX_W-1 -: 2];
    assign qidx = idx[QTR_W-1:0];

    // quadrants: cos, -sin, -cos, sin
    always_comb
    begin
        mag = quad[0] ? SIN_QTR[qidx] : COS_QTR[qidx];
        if (quad[0] ^ quad[1])
            value_next = -$signed({1'b0, mag});
        else
            value_next = $signed({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        if (load)
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: rtl/core/sinusoidal_grating_pixel_generator.sv
// Channel  Direction  Handshake         Beat
// in       receive    in_valid/in_stall   sgpg_pkg::pix_beat_t  (x, y, frame, segment)
// out      send       out_valid/out_stall sgpg_pkg::lum_beat_t  (luminance, clipped)
// cfg      receive    cfg_valid/cfg_ready index + 32-bit data, always ready
//
// Seven register stages: phase multiplies, phase sum and table index, cosine
// table read, amplitude multiply, temporal multiply, rounding, saturation.
// One beat per cycle while out_stall is low; out_valid marks the saturation register.
// Reset clears stage valid bits and loads register defaults; no clearing pass.
// Each stage holds only when its successor is full and held, so bubbles
// squeeze out and in_stall rises only with every stage full behind out_stall.
module sinusoidal_grating_pixel_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  sgpg_pkg::pix_beat_t               in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output sgpg_pkg::lum_beat_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sgpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data
);
    import sgpg_pkg::*;

    localparam logic signed [16:0] CT_ONE     = 17'sd32768;
    localparam logic [46:0]        ROUND_HALF = 47'd1 << 29;

    // configuration
    logic [1:0]  mode_reg;
    logic [15:0] mean_level_reg;
    logic [15:0] amplitude_reg;
    logic [31:0] x_step_reg;
    logic [31:0] y_step_reg;
    logic [31:0] offset_reg;
    logic [31:0] time_step_reg;
    logic [31:0] time_offset_reg;

    // stage valids and moves
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, out_valid_reg;
    logic ready1, ready2, ready3, ready4, ready5, ready6, ready7;

    // stage 1
    logic [31:0] px_reg, py_reg, ft_reg;
    logic [31:0] px_next, py_next, ft_next;
    logic [1:0]  seg1_reg;
    // stage 2
    cos_idx_t    sidx_reg, tidx_reg;
    cos_idx_t    sidx_next, tidx_next;
    logic [31:0] sphase, tphase;
    logic [1:0]  seg2_reg;
    // stage 3
    logic signed [COS_W-1:0] cs, ct_raw;
    logic [1:0]  seg3_reg;
    // stage 4
    logic signed [33:0] prod1_full;
    logic signed [31:0] prod1_reg, prod1_next;
    logic signed [16:0] ct_reg, ct_next;
    logic [1:0]  seg4_reg;
    // stage 5
    logic signed [48:0] prod_full;
    logic signed [46:0] prod_reg, prod_next;
    logic [1:0]  seg5_reg;
    // stage 6
    logic [46:0] abs_prod, rnd;
    logic [16:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic        blank6_reg, blank6_next;
    // output
    logic [16:0] up, dn;
    lum_beat_t   out_data_reg, out_data_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_DRIFT;
            mean_level_reg  <= 16'd32768;
            amplitude_reg   <= 16'd32768;
            x_step_reg      <= '0;
            y_step_reg      <= '0;
            offset_reg      <= '0;
            time_step_reg   <= '0;
            time_offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:        mode_reg        <= cfg_data[1:0];
                REG_MEAN:        mean_level_reg  <= cfg_data[15:0];
                REG_AMPLITUDE:   amplitude_reg   <= cfg_data[15:0];
                REG_X_STEP:      x_step_reg      <= cfg_data;
                REG_Y_STEP:      y_step_reg      <= cfg_data;
                REG_OFFSET:      offset_reg      <= cfg_data;
                REG_TIME_STEP:   time_step_reg   <= cfg_data;
                REG_TIME_OFFSET: time_offset_reg <= cfg_data;
            endcase
        end
    end

    assign ready7   = !out_valid_reg || !out_stall;
    assign ready6   = !v6_reg || ready7;
    assign ready5   = !v5_reg || ready6;
    assign ready4   = !v4_reg || ready5;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= in_valid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
            if (ready4)
                v4_reg <= v3_reg;
            if (ready5)
                v5_reg <= v4_reg;
            if (ready6)
                v6_reg <= v5_reg;
            if (ready7)
                out_valid_reg <= v6_reg;
        end
    end

    // stage 1: phase products, modulo 2^32
    assign px_next = {20'd0, in_data.pixel_x} * x_step_reg;
    assign py_next = {20'd0, in_data.pixel_y} * y_step_reg;
    assign ft_next = {16'd0, in_data.frame_index} * time_step_reg;

    // stage 2: phase sums, table index is the top bits
    always_comb
    begin
        sphase = px_reg + py_reg + offset_reg;
        if (mode_reg == MODE_DRIFT)
            sphase = sphase - ft_reg;
        tphase    = ft_reg + time_offset_reg;
        sidx_next = sphase[PHASE_W-1 -: COS_IDX_W];
        tidx_next = tphase[PHASE_W-1 -: COS_IDX_W];
    end

    // stage 3: cosine tables
    sgpg_cos_rom u_rom_space (
        .clk   (clk),
        .load  (ready3),
        .idx   (sidx_reg),
        .value (cs)
    );

    sgpg_cos_rom u_rom_time (
        .clk   (clk),
        .load  (ready3),
        .idx   (tidx_reg),
        .value (ct_raw)
    );

    // stage 4: amplitude * spatial cosine, fits 32 bits signed; time cosine in OSC mode, else unity
    assign prod1_full = $signed({1'b0, amplitude_reg}) * $signed({cs[COS_W-1], cs});
    assign prod1_next = prod1_full[31:0];
    assign ct_next    = (mode_reg == MODE_OSC) ? $signed({ct_raw[COS_W-1], ct_raw}) : CT_ONE;

    // stage 5: temporal factor
    assign prod_full = prod1_reg * ct_reg;
    assign prod_next = prod_full[46:0];

    // stage 6: divide by 2^30, half away from zero; segment sign
    always_comb
    begin
        abs_prod    = prod_reg[46] ? $unsigned(-prod_reg) : $unsigned(prod_reg);
        rnd         = abs_prod + ROUND_HALF;
        mag_next    = rnd[46:30];
        neg_next    = 1'b0;
        blank6_next = 1'b0;
        case (seg5_reg)
            SEG_GRATING:  neg_next = prod_reg[46];
            SEG_REVERSED: neg_next = !prod_reg[46];
            default:      blank6_next = 1'b1;
        endcase
    end

    // stage 7: mean +/- term, saturate
    always_comb
    begin
        up = {1'b0, mean_level_reg} + mag_reg;
        dn = {1'b0, mean_level_reg} - mag_reg;
        if (blank6_reg)
        begin
            out_data_next.luminance = mean_level_reg;
            out_data_next.clipped   = 1'b0;
        end
        else if (neg_reg)
        begin
            if (mag_reg > {1'b0, mean_level_reg})
            begin
                out_data_next.luminance = 16'h0000;
                out_data_next.clipped   = 1'b1;
            end
            else
            begin
                out_data_next.luminance = dn[15:0];
                out_data_next.clipped   = 1'b0;
            end
        end
        else if (up[16])
        begin
            out_data_next.luminance = 16'hFFFF;
            out_data_next.clipped   = 1'b1;
        end
        else
        begin
            out_data_next.luminance = up[15:0];
            out_data_next.clipped   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            ft_reg   <= ft_next;
            seg1_reg <= in_data.segment;
        end
        if (ready2)
        begin
            sidx_reg <= sidx_next;
            tidx_reg <= tidx_next;
            seg2_reg <= seg1_reg;
        end
        if (ready3)
            seg3_reg <= seg2_reg;
        if (ready4)
        begin
            prod1_reg <= prod1_next;
            ct_reg    <= ct_next;
            seg4_reg  <= seg3_reg;
        end
        if (ready5)
        begin
            prod_reg <= prod_next;
            seg5_reg <= seg4_reg;
        end
        if (ready6)
        begin
            mag_reg    <= mag_next;
            neg_reg    <= neg_next;
            blank6_reg <= blank6_next;
        end
        if (ready7)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_blank_is_mean: assert property (@(posedge clk) disable iff (!rst_n)
        (v6_reg && ready7 && blank6_reg) |=>
        (out_valid && out_data.luminance == mean_level_reg && !out_data.clipped))
        else $error("blank beat did not give the mean level");

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.clipped) |->
        (out_data.luminance == 16'h0000 || out_data.luminance == 16'hFFFF))
        else $error("clipped beat not at a rail");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output moving");

endmodule

// File: verif/sinusoidal_grating_pixel_generator_test.sv
module sinusoidal_grating_pixel_generator_test;
    import sgpg_pkg::*;

    localparam int              LUT_SIZE     = 1024;
    localparam longint          Q30_ONE      = 64'sd1073741824;
    localparam longint unsigned Q30_HALF_PI  = 64'd1686629713;
    localparam logic [1:0]      MODE_SPARE   = 2'd3;
    localparam logic [1:0]      SEG_SPARE    = 2'd3;
    localparam int              DRAIN_CYCLES = 12;
    localparam int              DRAIN_LIMIT  = 20000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    pix_beat_t            in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    lum_beat_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    // shadow copy of the register file
    logic [1:0]  cur_mode  = MODE_DRIFT;
    logic [15:0] mean_lvl  = 16'd32768;
    logic [15:0] amp       = 16'd32768;
    logic [31:0] x_step    = '0;
    logic [31:0] y_step    = '0;
    logic [31:0] ph_off    = '0;
    logic [31:0] t_step    = '0;
    logic [31:0] t_off     = '0;

    int          cos_q15 [LUT_SIZE];
    lum_beat_t   expected_lum [$];

    int          errors        = 0;
    int          pixels_sent   = 0;
    int          beats_checked = 0;
    int          clipped_seen  = 0;
    int          reg_writes    = 0;
    int          in_gap_pct    = 0;
    int          out_stall_pct = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sinusoidal_grating_pixel_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Q30 Taylor sum of cos or sin, rounded to a Q15 magnitude
    function automatic int taylor_q15(longint unsigned ang, bit want_sin);
        longint unsigned sq;
        longint unsigned t;
        longint unsigned n;
        longint          acc;
        sq  = (ang * ang) >> 30;
        t   = want_sin ? ang : 64'd1 << 30;
        acc = longint'(t);
        n   = want_sin ? 64'd2 : 64'd1;
        for (int k = 1; k < 10; k++)
        begin
            t = ((t * sq) >> 30) / (n * (n + 1));
            n = n + 2;
            if (k % 2)
                acc = acc - longint'(t);
            else
                acc = acc + longint'(t);
        end
        if (acc < 0)
            acc = 0;
        if (acc > Q30_ONE)
            acc = Q30_ONE;
        acc = (acc + 16384) >>> 15;
        if (acc > 32767)
            acc = 32767;
        return int'(acc);
    endfunction

    function automatic void build_cos_lut();
        logic [31:0]     q;
        longint unsigned ang;
        for (int i = 0; i < LUT_SIZE; i++)
        begin
            q   = 32'((64'(i) << 32) / LUT_SIZE);
            ang = (64'(q[29:0]) * Q30_HALF_PI) >> 30;
            case (q[31:30])
                2'd0:    cos_q15[i] = taylor_q15(ang, 1'b0);
                2'd1:    cos_q15[i] = -taylor_q15(ang, 1'b1);
                2'd2:    cos_q15[i] = -taylor_q15(ang, 1'b0);
                default: cos_q15[i] = taylor_q15(ang, 1'b1);
            endcase
        end
    endfunction

    function automatic int lut_cos(logic [31:0] ph);
        return cos_q15[(64'(ph) * LUT_SIZE) >> 32];
    endfunction

    function automatic lum_beat_t predict_luminance(pix_beat_t b);
        logic [31:0] sphase;
        logic [31:0] tphase;
        longint      cs;
        longint      ct;
        longint      prod;
        longint      mag;
        longint      term;
        longint      lvl;
        lum_beat_t   r;
        sphase = {20'd0, b.pixel_x} * x_step + {20'd0, b.pixel_y} * y_step + ph_off;
        tphase = {16'd0, b.frame_index} * t_step;
        if (cur_mode == MODE_DRIFT)
            sphase = sphase - tphase;
        cs = lut_cos(sphase);
        ct = 32768;
        if (cur_mode == MODE_OSC)
            ct = lut_cos(tphase + t_off);
        prod = longint'(amp) * cs * ct;
        mag  = prod < 0 ? -prod : prod;
        mag  = (mag + Q30_ONE / 2) / Q30_ONE;
        term = prod < 0 ? -mag : mag;
        case (b.segment)
            SEG_GRATING:  lvl = longint'(mean_lvl) + term;
            SEG_REVERSED: lvl = longint'(mean_lvl) - term;
            default:      lvl = longint'(mean_lvl);
        endcase
        r.clipped = 1'b0;
        if (lvl < 0)
        begin
            lvl       = 0;
            r.clipped = 1'b1;
        end
        else if (lvl > 65535)
        begin
            lvl       = 65535;
            r.clipped = 1'b1;
        end
        r.luminance = lvl[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH t=%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MODE:        cur_mode = val[1:0];
            REG_MEAN:        mean_lvl = val[15:0];
            REG_AMPLITUDE:   amp      = val[15:0];
            REG_X_STEP:      x_step   = val;
            REG_Y_STEP:      y_step   = val;
            REG_OFFSET:      ph_off   = val;
            REG_TIME_STEP:   t_step   = val;
            REG_TIME_OFFSET: t_off    = val;
            default:         ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_pixel(pix_beat_t b);
        @(negedge clk);
        if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = b;
        do
            @(posedge clk);
        while (in_stall);
        expected_lum.push_back(predict_luminance(b));
        pixels_sent++;
    endtask

    // pipeline empty: waits until every expected beat is back, then adds a slack wait
    task automatic wait_idle();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_lum.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_lum.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected beats never arrived", expected_lum.size()));
            expected_lum.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic pix_beat_t pix(int x, int y, int f, logic [1:0] seg);
        pix_beat_t b;
        b.pixel_x     = 12'(x);
        b.pixel_y     = 12'(y);
        b.frame_index = 16'(f);
        b.segment     = seg;
        return b;
    endfunction

    function automatic pix_beat_t rand_pixel();
        pix_beat_t b;
        int        pick;
        b.pixel_x     = 12'($urandom);
        b.pixel_y     = 12'($urandom);
        b.frame_index = 16'($urandom);
        pick          = $urandom_range(0, 9);
        if (pick == 0)
            b.segment = SEG_BLANK;
        else if (pick == 1)
            b.segment = SEG_SPARE;
        else if (pick < 6)
            b.segment = SEG_GRATING;
        else
            b.segment = SEG_REVERSED;
        return b;
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return 32'($urandom_range(0, 32'h00FF_FFFF));
            6:       return -32'($urandom_range(0, 32'h00FF_FFFF));
            default: return $urandom;
        endcase
    endfunction

    // upper bits of the narrow registers carry junk that must be dropped
    task automatic randomize_settings();
        set_reg(REG_MODE, ($urandom & ~32'h3) | 32'($urandom_range(0, 3)));
        set_reg(REG_MEAN, ($urandom & 32'hFFFF_0000) | 32'(pick16()));
        set_reg(REG_AMPLITUDE, ($urandom & 32'hFFFF_0000) | 32'(pick16()));
        set_reg(REG_X_STEP, pick32());
        set_reg(REG_Y_STEP, pick32());
        set_reg(REG_OFFSET, pick32());
        set_reg(REG_TIME_STEP, pick32());
        set_reg(REG_TIME_OFFSET, pick32());
    endtask

    task automatic test_reset_defaults();
        send_pixel(pix(0, 0, 0, SEG_BLANK));
        send_pixel(pix(0, 0, 0, SEG_GRATING));
        send_pixel(pix(0, 0, 0, SEG_REVERSED));
        send_pixel(pix(0, 0, 0, SEG_SPARE));
    endtask

    task automatic test_register_extremes();
        wait_idle();
        set_reg(REG_MODE, 32'hFFFF_FFFC);
        set_reg(REG_MEAN, 32'h1234_FFFF);
        set_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
        set_reg(REG_X_STEP, 32'h7FFF_FFFF);
        set_reg(REG_Y_STEP, 32'h8000_0000);
        set_reg(REG_OFFSET, 32'hFFFF_FFFF);
        set_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
        set_reg(REG_TIME_OFFSET, 32'hFFFF_FFFF);
        send_pixel(pix(4095, 4095, 65535, SEG_GRATING));
        send_pixel(pix(4095, 0, 1, SEG_REVERSED));
        send_pixel(pix(0, 4095, 65535, SEG_GRATING));
    endtask

    task automatic test_saturation();
        wait_idle();
        set_reg(REG_MODE, 32'(MODE_STATIC));
        set_reg(REG_MEAN, 32'h0000_0000);
        set_reg(REG_X_STEP, 32'h0);
        set_reg(REG_Y_STEP, 32'h0);
        set_reg(REG_OFFSET, 32'h0);
        send_pixel(pix(17, 33, 9, SEG_REVERSED));
        send_pixel(pix(17, 33, 9, SEG_GRATING));
        wait_idle();
        set_reg(REG_OFFSET, 32'h8000_0000);
        send_pixel(pix(1, 2, 3, SEG_GRATING));
    endtask

    task automatic test_modes();
        wait_idle();
        set_reg(REG_MEAN, 32'd32768);
        set_reg(REG_AMPLITUDE, 32'd30000);
        set_reg(REG_X_STEP, 32'h0123_4567);
        set_reg(REG_Y_STEP, 32'hFEDC_BA98);
        set_reg(REG_OFFSET, 32'h1000_0000);
        set_reg(REG_TIME_STEP, 32'h0200_0000);
        set_reg(REG_TIME_OFFSET, 32'h4000_0000);
        set_reg(REG_MODE, 32'(MODE_DRIFT));
        send_pixel(pix(10, 20, 5, SEG_GRATING));
        send_pixel(pix(10, 20, 6, SEG_REVERSED));
        wait_idle();
        set_reg(REG_MODE, 32'(MODE_OSC));
        send_pixel(pix(10, 20, 5, SEG_GRATING));
        send_pixel(pix(3, 7, 100, SEG_REVERSED));
        wait_idle();
        set_reg(REG_MODE, 32'(MODE_STATIC));
        send_pixel(pix(10, 20, 5, SEG_GRATING));
        send_pixel(pix(10, 20, 6, SEG_GRATING));
        wait_idle();
        set_reg(REG_MODE, 32'(MODE_SPARE));
        send_pixel(pix(10, 20, 5, SEG_REVERSED));
        send_pixel(pix(0, 0, 0, SEG_BLANK));
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            randomize_settings();
            in_gap_pct    = (ph % 3 == 0) ? 0 : 5 + 10 * (ph % 3);
            out_stall_pct = (ph % 4 == 1) ? 0 : 3 + 7 * (ph % 4);
            repeat (200) send_pixel(rand_pixel());
        end
    endtask

    task automatic test_back_to_back();
        wait_idle();
        in_gap_pct    = 0;
        out_stall_pct = 0;
        randomize_settings();
        repeat (300) send_pixel(rand_pixel());
    endtask

    always
    begin
        @(negedge clk);
        if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct)
        begin
            out_stall = 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clk);
            out_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        lum_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_lum.size() == 0)
                report_mismatch($sformatf("unexpected beat lum=%0d clipped=%0b",
                                          out_data.luminance, out_data.clipped));
            else
            begin
                want = expected_lum.pop_front();
                if (out_data.luminance !== want.luminance)
                    report_mismatch($sformatf("luminance got %0d want %0d",
                                              out_data.luminance, want.luminance));
                if (out_data.clipped !== want.clipped)
                    report_mismatch($sformatf("clipped got %0b want %0b",
                                              out_data.clipped, want.clipped));
                if (want.clipped)
                    clipped_seen++;
                beats_checked++;
            end
        end
    end

    initial
    begin
        build_cos_lut();
        in_gap_pct    = 20;
        out_stall_pct = 20;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_saturation();
        test_modes();
        test_random_settings();
        test_back_to_back();
        wait_idle();
        $display("Covered %0d pixels, %0d result beats checked (%0d saturated), %0d reg writes",
                 pixels_sent, beats_checked, clipped_seen, reg_writes);
        $display("All modes and segments, register extremes, random idling and backpressure");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timeout: pipeline did not drain");
        $display("Regression FAIL");
        $finish;
    end

endmodule
